// File: design/dst2d_pkg.sv
// Shared types and constants for the 2D diffusion stencil unit.
// No dependencies; every other design file refers to this package by scoped names.
package dst2d_pkg;

	localparam int VALUE_BITS    = 16;
	localparam int DIM_BITS      = 8;
	localparam int DIM_MAX       = (1 << DIM_BITS) - 1;
	localparam int STEP_BITS     = 10;
	localparam int POS_BITS      = 2 * DIM_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = STEP_BITS;

	// five-cell sum plus rounding bias, and the reciprocal divide by five
	localparam int SUM_BITS    = VALUE_BITS + 3;
	localparam int DIVISOR     = 5;
	localparam int ROUND_BIAS  = 2;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RECIP_BITS  = 19;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam int DIV_LAT     = 2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_STEP_COUNT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		NB_CENTER = 3'd0,
		NB_WEST   = 3'd1,
		NB_EAST   = 3'd2,
		NB_NORTH  = 3'd3,
		NB_SOUTH  = 3'd4
	} nb_t;

	typedef struct packed {
		logic                  req_type;
		logic [VALUE_BITS-1:0] cell_value;
	} in_word_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] result_value;
		logic                  last_cell;
	} out_word_t;

	typedef struct packed {
		logic cfg_we;
		logic pos_clr;
		logic load_we;
		logic read_en;
		logic comp_init;
		logic nb_rd;
		nb_t  nb_sel;
		logic div_start;
		logic cell_wr;
		logic step_next;
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic read_last;
		logic steps_zero;
		logic step_end;
		logic steps_done;
		logic div_done;
	} sts_t;

endpackage

// File: design/dst2d_div5.sv
// Divide by five through a registered reciprocal multiply, result registered with done.
// Depends on dst2d_pkg.
module dst2d_div5 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dst2d_pkg::SUM_BITS-1:0]  dividend,
	output logic                            done,
	output logic [dst2d_pkg::VALUE_BITS-1:0] quotient
);

	localparam int SUMB  = dst2d_pkg::SUM_BITS;
	localparam int PRODB = dst2d_pkg::PROD_BITS;
	localparam int VB    = dst2d_pkg::VALUE_BITS;

	logic [SUMB-1:0]  dvd_q;
	logic [VB-1:0]    quo_q;
	logic             run_q;
	logic             done_q;

	logic [PRODB-1:0] prod;

	// floor(n / 5) = (n * ceil(2^21 / 5)) >> 21, exact for every n below 2^19
	assign prod = PRODB'(dvd_q) * PRODB'(dst2d_pkg::RECIP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) dvd_q <= dividend;
		if (run_q) quo_q <= prod[dst2d_pkg::RECIP_SHIFT +: VB];
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef ASSERT_OFF
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(dst2d_pkg::DIV_LAT) done)
		else $error("divide result not ready on schedule");
`endif

endmodule

// File: design/dst2d_ctrl.sv
// Controller FSM: load and readout phases, and the per-cell stencil sequence.
// Depends on dst2d_pkg; drives dst2d_dp through cmd_t, watches sts_t.
module dst2d_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 req_type,
	output logic                                 busy,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dst2d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  dst2d_pkg::sts_t                      sts,
	output dst2d_pkg::cmd_t                      cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_READ,
		S_FETCH,
		S_SUM,
		S_DIV
	} state_t;

	state_t          state_q;
	dst2d_pkg::nb_t  nb_q;

	logic accept;
	logic cfg_we;
	logic cfg_hit;

	assign busy      = !(state_q == S_LOAD || state_q == S_READ);
	assign accept    = start && !busy;
	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_we && (cfg_index == dst2d_pkg::CFG_GRID_WIDTH ||
		cfg_index == dst2d_pkg::CFG_GRID_HEIGHT || cfg_index == dst2d_pkg::CFG_STEP_COUNT);

	always_comb begin
		cmd        = '0;
		cmd.nb_sel = nb_q;
		cmd.cfg_we = cfg_we;
		cmd.pos_clr = cfg_hit;
		unique case (state_q)
			S_LOAD: begin
				if (accept && req_type == dst2d_pkg::REQ_LOAD) begin
					cmd.load_we = 1'b1;
					if (sts.load_last) begin
						cmd.pos_clr   = 1'b1;
						cmd.comp_init = 1'b1;
					end
				end
			end
			S_READ: begin
				if (accept && req_type == dst2d_pkg::REQ_READ) begin
					cmd.read_en = 1'b1;
					cmd.pos_clr = sts.read_last;
				end
			end
			S_FETCH: cmd.nb_rd = 1'b1;
			S_SUM:   cmd.div_start = 1'b1;
			S_DIV: begin
				if (sts.div_done) begin
					cmd.cell_wr   = 1'b1;
					cmd.step_next = sts.step_end && !sts.steps_done;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			nb_q    <= dst2d_pkg::NB_CENTER;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept && req_type == dst2d_pkg::REQ_LOAD && sts.load_last) begin
						state_q <= sts.steps_zero ? S_READ : S_FETCH;
						nb_q    <= dst2d_pkg::NB_CENTER;
					end
				end
				S_READ: begin
					if (cfg_hit) begin
						state_q <= S_LOAD;
					end else if (accept && req_type == dst2d_pkg::REQ_READ && sts.read_last) begin
						state_q <= S_LOAD;
					end
				end
				S_FETCH: begin
					unique case (nb_q)
						dst2d_pkg::NB_CENTER: nb_q <= dst2d_pkg::NB_WEST;
						dst2d_pkg::NB_WEST:   nb_q <= dst2d_pkg::NB_EAST;
						dst2d_pkg::NB_EAST:   nb_q <= dst2d_pkg::NB_NORTH;
						dst2d_pkg::NB_NORTH:  nb_q <= dst2d_pkg::NB_SOUTH;
						default: begin
							nb_q    <= dst2d_pkg::NB_CENTER;
							state_q <= S_SUM;
						end
					endcase
				end
				S_SUM: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= (sts.step_end && sts.steps_done) ? S_READ : S_FETCH;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cmd.load_we))
		else $error("compute pass started without a final load");
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !(cmd.nb_rd || cmd.div_start || cmd.cell_wr))
		else $error("config port open during compute");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divide result arrived outside the wait state");
`endif

endmodule

// File: design/dst2d_dp.sv
// Datapath: config registers, two grid planes, position and cell counters, sum and divide.
// Depends on dst2d_pkg and dst2d_div5; controlled by dst2d_ctrl via cmd_t/sts_t.
module dst2d_dp #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dst2d_pkg::cmd_t                       cmd,
	output dst2d_pkg::sts_t                       sts,
	input  dst2d_pkg::in_word_t                   item,
	input  logic [dst2d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [dst2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                  result_valid,
	output dst2d_pkg::out_word_t                  result
);

	localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
	localparam int AB        = $clog2(CELLS);
	localparam int DB        = dst2d_pkg::DIM_BITS;
	localparam int PB        = dst2d_pkg::POS_BITS;
	localparam int SB        = dst2d_pkg::STEP_BITS;
	localparam int VB        = dst2d_pkg::VALUE_BITS;
	localparam int SUMB      = dst2d_pkg::SUM_BITS;
	localparam logic [DB-1:0] W_CAP = (MAX_WIDTH > dst2d_pkg::DIM_MAX) ?
		DB'(dst2d_pkg::DIM_MAX) : DB'(MAX_WIDTH);
	localparam logic [DB-1:0] H_CAP = (MAX_HEIGHT > dst2d_pkg::DIM_MAX) ?
		DB'(dst2d_pkg::DIM_MAX) : DB'(MAX_HEIGHT);

	logic [DB-1:0]   gw_q, gh_q;
	logic [SB-1:0]   steps_q;
	logic [PB-1:0]   load_pos_q, read_pos_q;
	logic [SB-1:0]   t_q;
	logic [DB-1:0]   x_q, y_q;
	logic [AB-1:0]   idx_q;
	logic [SUMB-1:0] acc_q;
	logic            acc_en_s1, acc_first_s1;
	logic            rsel_s1, last_s1, valid_s1;
	logic [VB-1:0]   rd0_q, rd1_q;

	logic [VB-1:0]   plane0_mem [CELLS];
	logic [VB-1:0]   plane1_mem [CELLS];

	logic [DB-1:0]   gw, gh;
	logic [PB-1:0]   total_m1;
	logic [AB-1:0]   w_a, nb_addr, raddr, waddr;
	logic [VB-1:0]   rdata, wdata, quotient;
	logic [SUMB-1:0] div_in;
	logic            x_end, re, we0, we1, div_done;

	// clamp the configured dimensions into the supported range
	assign gw = (gw_q < DB'(3)) ? DB'(3) : (gw_q > W_CAP) ? W_CAP : gw_q;
	assign gh = (gh_q < DB'(3)) ? DB'(3) : (gh_q > H_CAP) ? H_CAP : gh_q;
	assign total_m1 = PB'(gw) * PB'(gh) - PB'(1);
	assign w_a = AB'(gw);

	assign x_end = (x_q == gw - DB'(2));

	assign sts.load_last  = (load_pos_q == total_m1);
	assign sts.read_last  = (read_pos_q == total_m1);
	assign sts.steps_zero = (steps_q == '0);
	assign sts.step_end   = x_end && (y_q == gh - DB'(2));
	assign sts.steps_done = ((t_q + SB'(1)) == steps_q);
	assign sts.div_done   = div_done;

	always_comb begin
		unique case (cmd.nb_sel)
			dst2d_pkg::NB_CENTER: nb_addr = idx_q;
			dst2d_pkg::NB_WEST:   nb_addr = idx_q - AB'(1);
			dst2d_pkg::NB_EAST:   nb_addr = idx_q + AB'(1);
			dst2d_pkg::NB_NORTH:  nb_addr = idx_q - w_a;
			dst2d_pkg::NB_SOUTH:  nb_addr = idx_q + w_a;
			default:              nb_addr = idx_q;
		endcase
	end

	// plane t[0] is the source of step t, the other plane its destination
	assign raddr = cmd.read_en ? AB'(read_pos_q) : nb_addr;
	assign re    = cmd.read_en || cmd.nb_rd;
	assign waddr = cmd.load_we ? AB'(load_pos_q) : idx_q;
	assign wdata = cmd.load_we ? item.cell_value : quotient;
	assign we0   = cmd.load_we || (cmd.cell_wr && t_q[0]);
	assign we1   = cmd.load_we || (cmd.cell_wr && !t_q[0]);
	assign rdata = rsel_s1 ? rd1_q : rd0_q;

	assign div_in = acc_q + SUMB'(rdata) + SUMB'(dst2d_pkg::ROUND_BIAS);

	always_ff @(posedge clk) begin
		if (we0) plane0_mem[waddr] <= wdata;
		if (re)  rd0_q <= plane0_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we1) plane1_mem[waddr] <= wdata;
		if (re)  rd1_q <= plane1_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= DB'(128);
			gh_q    <= DB'(128);
			steps_q <= SB'(20);
		end else if (cmd.cfg_we) begin
			unique case (cfg_index)
				dst2d_pkg::CFG_GRID_WIDTH:  gw_q    <= cfg_data[DB-1:0];
				dst2d_pkg::CFG_GRID_HEIGHT: gh_q    <= cfg_data[DB-1:0];
				dst2d_pkg::CFG_STEP_COUNT:  steps_q <= cfg_data[SB-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			read_pos_q <= '0;
		end else if (cmd.pos_clr) begin
			load_pos_q <= '0;
			read_pos_q <= '0;
		end else begin
			if (cmd.load_we) load_pos_q <= load_pos_q + PB'(1);
			if (cmd.read_en) read_pos_q <= read_pos_q + PB'(1);
		end
	end

	// interior walk: x,y from 1 to dim-2; idx tracks y*w+x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q   <= '0;
			x_q   <= DB'(1);
			y_q   <= DB'(1);
			idx_q <= '0;
		end else if (cmd.comp_init || cmd.step_next) begin
			t_q   <= cmd.comp_init ? '0 : t_q + SB'(1);
			x_q   <= DB'(1);
			y_q   <= DB'(1);
			idx_q <= w_a + AB'(1);
		end else if (cmd.cell_wr) begin
			if (x_end) begin
				x_q   <= DB'(1);
				y_q   <= y_q + DB'(1);
				idx_q <= idx_q + AB'(3);
			end else begin
				x_q   <= x_q + DB'(1);
				idx_q <= idx_q + AB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.nb_rd;
			valid_s1  <= cmd.read_en;
		end
	end

	always_ff @(posedge clk) begin
		acc_first_s1 <= cmd.nb_rd && (cmd.nb_sel == dst2d_pkg::NB_CENTER);
		rsel_s1      <= cmd.read_en ? steps_q[0] : t_q[0];
		last_s1      <= sts.read_last;
		if (acc_en_s1) begin
			acc_q <= acc_first_s1 ? SUMB'(rdata) : acc_q + SUMB'(rdata);
		end
	end

	dst2d_div5 u_div5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_in),
		.done     (div_done),
		.quotient (quotient)
	);

	assign result_valid        = valid_s1;
	assign result.result_value = rdata;
	assign result.last_cell    = last_s1;

`ifndef ASSERT_OFF
	a_last_ends_readout: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_cell |=> !result_valid)
		else $error("word delivered after the final cell");
`endif

endmodule

// File: design/diffusion_stencil_2d_unit.sv
// Top level of the 2D diffusion stencil unit (5-point Jacobi, two ping-pong planes).
// Depends on dst2d_pkg, dst2d_ctrl and dst2d_dp.
//
// Loads stream in one word per cycle, in raster order; a read while loading is ignored.
// Accepting the final cell raises busy for the compute pass: each interior cell uses
// five reads of the single plane read port, then a state to close the sum, then the
// divide-by-five unit, whose result writes the cell. With step_count of zero busy never
// rises. Readout then streams one word per cycle; each result appears on result in the
// cycle after its start, flagged by result_valid for that single cycle, with last_cell on
// the final cell, after which the unit is loading again. The receiver cannot stall
// results. Config writes are taken only while not busy and not starting, and those to a
// defined index restart loading; the grid memory needs no clearing after reset.
module diffusion_stencil_2d_unit #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  dst2d_pkg::in_word_t                  item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dst2d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [dst2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                                 result_valid,
	output dst2d_pkg::out_word_t                 result
);

	dst2d_pkg::cmd_t cmd;
	dst2d_pkg::sts_t sts;

	dst2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (item.req_type),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.sts       (sts),
		.cmd       (cmd)
	);

	dst2d_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
